### rtl/core/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared widths, types and constant tables of the waveform sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pwg_pkg;

	localparam int INDEX_BITS     = 17;
	localparam int SAMPLE_BITS    = 16;
	localparam int PHASE_BITS     = 16;
	localparam int QUO_BITS       = (SAMPLE_BITS > PHASE_BITS) ? SAMPLE_BITS : PHASE_BITS;
	localparam int NUM_BITS       = INDEX_BITS + QUO_BITS;
	localparam int CFG_DATA_BITS  = (INDEX_BITS > SAMPLE_BITS) ? INDEX_BITS : SAMPLE_BITS;
	localparam int CFG_INDEX_BITS = 2;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam int X_BITS       = 32;
	localparam int X2_BITS      = 33;
	localparam int P_BITS       = 33;
	localparam int RECIP_BITS   = 33;
	localparam int RECIP_SHIFT  = 33;
	localparam int DIVC_BITS    = 9;
	localparam int SUM_BITS     = 36;
	localparam int SERIES_TERMS = 10;
	localparam int SOFF_BITS    = 16;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHAPE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AMP    = 2'd2;

	typedef enum logic [1:0] {
		SHAPE_SINE   = 2'd0,
		SHAPE_SQUARE = 2'd1,
		SHAPE_TRI    = 2'd2,
		SHAPE_SAW    = 2'd3
	} shape_t;

	typedef struct packed {
		logic                   is_sine;
		logic                   direct;
		logic [SAMPLE_BITS-1:0] direct_val;
		logic                   last;
		logic                   oor;
	} meta_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] op;
		logic [INDEX_BITS-1:0] divisor;
		meta_t                 m;
	} item_t;

	typedef struct packed {
		meta_t               m;
		logic [QUO_BITS-1:0] q;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// series divisors: sine uses (2k)(2k+1), cosine (2k-1)(2k)
	function automatic logic [DIVC_BITS-1:0] series_divc(input int k, input logic odd);
		logic [DIVC_BITS-1:0] d;
		d = '0;
		if (odd) begin
			case (k)
				1: d = 9'd6;
				2: d = 9'd20;
				3: d = 9'd42;
				4: d = 9'd72;
				5: d = 9'd110;
				6: d = 9'd156;
				7: d = 9'd210;
				8: d = 9'd272;
				9: d = 9'd342;
				default: d = 9'd1;
			endcase
		end else begin
			case (k)
				1: d = 9'd2;
				2: d = 9'd12;
				3: d = 9'd30;
				4: d = 9'd56;
				5: d = 9'd90;
				6: d = 9'd132;
				7: d = 9'd182;
				8: d = 9'd240;
				9: d = 9'd306;
				default: d = 9'd1;
			endcase
		end
		return d;
	endfunction

	// floor(2^33 / divisor)
	function automatic logic [RECIP_BITS-1:0] series_recip(input int k, input logic odd);
		logic [RECIP_BITS-1:0] r;
		r = '0;
		if (odd) begin
			case (k)
				1: r = 33'd1431655765;
				2: r = 33'd429496729;
				3: r = 33'd204522252;
				4: r = 33'd119304647;
				5: r = 33'd78090314;
				6: r = 33'd55063683;
				7: r = 33'd40904450;
				8: r = 33'd31580641;
				9: r = 33'd25116767;
				default: r = 33'd0;
			endcase
		end else begin
			case (k)
				1: r = 33'd4294967296;
				2: r = 33'd715827882;
				3: r = 33'd286331153;
				4: r = 33'd153391689;
				5: r = 33'd95443717;
				6: r = 33'd65075262;
				7: r = 33'd47197442;
				8: r = 33'd35791394;
				9: r = 33'd28071681;
				default: r = 33'd0;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/pwg_front.sv
// ----------------------------------------------------------------------------
// pwg_front
// Classifies an incoming index: range flags, shape, dividend and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_front (
	input  wire logic [pwg_pkg::INDEX_BITS-1:0]  sample_index,
	input  wire pwg_pkg::shape_t                 shape,
	input  wire logic [pwg_pkg::INDEX_BITS-1:0]  period,
	input  wire logic [pwg_pkg::SAMPLE_BITS-1:0] amp,
	output pwg_pkg::item_t                       item
);

	logic [pwg_pkg::INDEX_BITS-1:0] half;
	logic [pwg_pkg::INDEX_BITS-1:0] n_m1;
	logic                           oor;
	logic                           below_half;

	assign half       = period >> 1;
	assign n_m1       = period - 1'b1;
	assign oor        = sample_index >= period;
	assign below_half = sample_index < half;

	always_comb begin
		item              = '0;
		item.op           = sample_index;
		item.divisor      = period;
		item.m.last       = !oor && (sample_index == n_m1);
		item.m.oor        = oor;
		case (shape)
			pwg_pkg::SHAPE_SINE: begin
				item.m.is_sine = 1'b1;
			end
			pwg_pkg::SHAPE_SQUARE: begin
				item.m.direct     = 1'b1;
				item.m.direct_val = below_half ? '0 : amp;
			end
			pwg_pkg::SHAPE_TRI: begin
				item.divisor = half;
				item.op      = below_half ? sample_index : (n_m1 - sample_index);
				if (half == '0) begin
					item.m.direct = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (oor) begin
			item.m.is_sine    = 1'b0;
			item.m.direct     = 1'b1;
			item.m.direct_val = '0;
		end
	end

endmodule

`default_nettype wire

### rtl/core/pwg_queue.sv
// ----------------------------------------------------------------------------
// pwg_queue
// Short item queue between the classifying front and the compute back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pwg_pkg::item_t push_item,
	input  wire logic     pop,
	output pwg_pkg::item_t pop_item,
	output pwg_pkg::qstat_t stat
);

	pwg_pkg::item_t                       mem_q [pwg_pkg::QDEPTH];
	logic [pwg_pkg::QPTR_BITS-1:0]        wr_ptr_q;
	logic [pwg_pkg::QPTR_BITS-1:0]        rd_ptr_q;
	logic [pwg_pkg::QCNT_BITS-1:0]        cnt_q;

	assign stat.full  = cnt_q == pwg_pkg::QCNT_BITS'(pwg_pkg::QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/pwg_div.sv
// ----------------------------------------------------------------------------
// pwg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [pwg_pkg::NUM_BITS-1:0]  num,
	input  wire logic [pwg_pkg::INDEX_BITS-1:0] divisor,
	input  wire pwg_pkg::meta_t                in_meta,
	output logic                               res_valid,
	output pwg_pkg::res_t                      res
);

	localparam int QB = pwg_pkg::QUO_BITS;
	localparam int IB = pwg_pkg::INDEX_BITS;

	logic                           v_st   [QB+1];
	logic [IB-1:0]                  rem_st [QB+1];
	logic [QB-1:0]                  q_st   [QB+1];
	logic [pwg_pkg::NUM_BITS-1:0]   num_st [QB+1];
	logic [IB-1:0]                  dv_st  [QB+1];
	pwg_pkg::meta_t                 m_st   [QB+1];

	assign v_st[0]   = in_valid;
	assign rem_st[0] = num[pwg_pkg::NUM_BITS-1:QB];
	assign q_st[0]   = '0;
	assign num_st[0] = num;
	assign dv_st[0]  = divisor;
	assign m_st[0]   = in_meta;

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [IB:0] trial;
		logic        ge;
		logic [IB:0] diff;

		assign trial = {rem_st[j], num_st[j][QB-1-j]};
		assign ge    = trial >= {1'b0, dv_st[j]};
		assign diff  = trial - {1'b0, dv_st[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[j+1] <= 1'b0;
			end else if (en) begin
				v_st[j+1] <= v_st[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j+1] <= ge ? diff[IB-1:0] : trial[IB-1:0];
				q_st[j+1]   <= {q_st[j][QB-2:0], ge};
				num_st[j+1] <= num_st[j];
				dv_st[j+1]  <= dv_st[j];
				m_st[j+1]   <= m_st[j];
			end
		end
	end

	assign res_valid = v_st[QB];
	assign res.m     = m_st[QB];
	assign res.q     = q_st[QB];

endmodule

`default_nettype wire

### rtl/core/pwg_sine.sv
// ----------------------------------------------------------------------------
// pwg_sine
// Pipelined Q1.15 sine of a 16-bit phase by quadrant and power series.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_sine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire pwg_pkg::res_t                 in_res,
	output logic                               out_valid,
	output pwg_pkg::res_t                      out_res,
	output logic [pwg_pkg::SOFF_BITS-1:0]      out_soff
);

	localparam int NT = pwg_pkg::SERIES_TERMS;

	logic [pwg_pkg::PHASE_BITS-1:0] phase;
	logic [46:0]                    xprod;

	logic                      va_q;
	logic [pwg_pkg::X_BITS-1:0] x_q;
	logic                      odd_a_q;
	logic                      neg_a_q;
	pwg_pkg::res_t             res_a_q;
	logic [63:0]               xx;

	logic                         vt    [NT];
	logic [31:0]                  termt [NT];
	logic signed [pwg_pkg::SUM_BITS-1:0] sumt [NT];
	logic [pwg_pkg::X2_BITS-1:0]  x2t   [NT];
	logic                         oddt  [NT];
	logic                         negt  [NT];
	pwg_pkg::res_t                rest  [NT];

	logic [pwg_pkg::SUM_BITS-2:0] vpos;
	logic [pwg_pkg::SUM_BITS-1:0] vrnd;
	logic [19:0]                  mag;
	logic [pwg_pkg::SOFF_BITS-1:0] soff;

	assign phase = in_res.q[pwg_pkg::PHASE_BITS-1:0];
	assign xprod = 47'(phase[13:0]) * 47'(pwg_pkg::PI_Q30) + 47'd8192;
	assign xx    = 64'(x_q) * 64'(x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= 1'b0;
			vt[0] <= 1'b0;
		end else if (en) begin
			va_q  <= in_valid;
			vt[0] <= va_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q      <= xprod[45:14];
			odd_a_q  <= !phase[14];
			neg_a_q  <= phase[15];
			res_a_q  <= in_res;
			x2t[0]   <= xx[63:31];
			termt[0] <= odd_a_q ? x_q : 32'h8000_0000;
			sumt[0]  <= $signed(pwg_pkg::SUM_BITS'(odd_a_q ? x_q : 32'h8000_0000));
			oddt[0]  <= odd_a_q;
			negt[0]  <= neg_a_q;
			rest[0]  <= res_a_q;
		end
	end

	for (genvar k = 1; k < NT; k++) begin : g_term
		logic [64:0]                    pprod;
		logic [65:0]                    rprod;
		logic [pwg_pkg::RECIP_BITS-1:0] recip;
		logic [pwg_pkg::DIVC_BITS-1:0]  divc;
		logic [40:0]                    qd;
		logic [33:0]                    rem;
		logic [31:0]                    tval;

		logic                           vA, vB;
		logic [pwg_pkg::P_BITS-1:0]     pA, pB;
		logic [31:0]                    q0B;
		logic signed [pwg_pkg::SUM_BITS-1:0] sumA, sumB;
		logic [pwg_pkg::X2_BITS-1:0]    x2A, x2B;
		logic                           oddA, oddB, negA, negB;
		pwg_pkg::res_t                  resA, resB;

		assign pprod = 65'(termt[k-1]) * 65'(x2t[k-1]);
		assign recip = pwg_pkg::series_recip(k, oddA);
		assign rprod = 66'(pA) * 66'(recip);
		assign divc  = pwg_pkg::series_divc(k, oddB);
		assign qd    = 41'(q0B) * 41'(divc);
		assign rem   = 34'(pB) - qd[33:0];
		assign tval  = q0B + 32'(rem >= 34'(divc));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vA    <= 1'b0;
				vB    <= 1'b0;
				vt[k] <= 1'b0;
			end else if (en) begin
				vA    <= vt[k-1];
				vB    <= vA;
				vt[k] <= vB;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pA       <= pprod[63:31];
				sumA     <= sumt[k-1];
				x2A      <= x2t[k-1];
				oddA     <= oddt[k-1];
				negA     <= negt[k-1];
				resA     <= rest[k-1];
				pB       <= pA;
				q0B      <= rprod[64:pwg_pkg::RECIP_SHIFT];
				sumB     <= sumA;
				x2B      <= x2A;
				oddB     <= oddA;
				negB     <= negA;
				resB     <= resA;
				termt[k] <= tval;
				sumt[k]  <= (k % 2 == 1) ? sumB - $signed(pwg_pkg::SUM_BITS'(tval))
				                         : sumB + $signed(pwg_pkg::SUM_BITS'(tval));
				x2t[k]   <= x2B;
				oddt[k]  <= oddB;
				negt[k]  <= negB;
				rest[k]  <= resB;
			end
		end
	end

	assign vpos = sumt[NT-1][pwg_pkg::SUM_BITS-1] ? '0 : sumt[NT-1][pwg_pkg::SUM_BITS-2:0];
	assign vrnd = pwg_pkg::SUM_BITS'(vpos) + pwg_pkg::SUM_BITS'(32768);
	assign mag  = vrnd[35:16];

	always_comb begin
		if (negt[NT-1]) begin
			soff = (mag >= 20'd32768) ? '0 : (16'h8000 - mag[15:0]);
		end else begin
			soff = (mag >= 20'd32768) ? 16'hFFFF : (16'h8000 + mag[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vt[NT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res  <= rest[NT-1];
			out_soff <= soff;
		end
	end

endmodule

`default_nettype wire

### rtl/core/periodic_waveform_sample_generator.sv
// throughput: one index per cycle while the output is not stalled, set by the fully
// pipelined divider and sine series
// a four-entry queue behind the classifier absorbs output stalls
// reset: asynchronous; shape sine, period 870, amplitude 65535, pipeline empty
// ----------------------------------------------------------------------------
// periodic_waveform_sample_generator
// Sample of a sine, square, triangle or sawtooth wave at an index in a period.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_waveform_sample_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pwg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [pwg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [pwg_pkg::INDEX_BITS-1:0]      sample_index,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [pwg_pkg::SAMPLE_BITS-1:0]          sample_value,
	output logic                                     last_of_period,
	output logic                                     index_out_of_range
);

	localparam int IB = pwg_pkg::INDEX_BITS;
	localparam int SB = pwg_pkg::SAMPLE_BITS;

	pwg_pkg::shape_t shape_q;
	logic [IB-1:0]   period_q;
	logic [SB-1:0]   amp_q;

	pwg_pkg::item_t  front_item;
	pwg_pkg::item_t  pop_item;
	pwg_pkg::qstat_t qstat;
	logic            push;
	logic            pop;
	logic            en;

	logic                          v_s1;
	pwg_pkg::item_t                item_s1;
	logic                          v_s2;
	logic [pwg_pkg::NUM_BITS-1:0]  num_s2;
	logic [IB-1:0]                 div_s2;
	pwg_pkg::meta_t                meta_s2;

	logic                          dv_valid;
	pwg_pkg::res_t                 dv_res;
	logic                          sn_valid;
	pwg_pkg::res_t                 sn_res;
	logic [pwg_pkg::SOFF_BITS-1:0] sn_soff;
	logic [pwg_pkg::SOFF_BITS+SB-1:0] sine_prod;
	logic [SB-1:0]                 sample_d;

	logic          out_valid_q;
	logic [SB-1:0] sample_q;
	logic          last_q;
	logic          oor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= pwg_pkg::SHAPE_SINE;
			period_q <= IB'(870);
			amp_q    <= SB'(65535);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pwg_pkg::CFG_SHAPE:  shape_q  <= pwg_pkg::shape_t'(cfg_data[1:0]);
				pwg_pkg::CFG_PERIOD: period_q <= cfg_data[IB-1:0];
				pwg_pkg::CFG_AMP:    amp_q    <= cfg_data[SB-1:0];
				default: begin
				end
			endcase
		end
	end

	pwg_front u_front (
		.sample_index (sample_index),
		.shape        (shape_q),
		.period       (period_q),
		.amp          (amp_q),
		.item         (front_item)
	);

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;
	assign en       = !out_valid_q || !out_stall;
	assign pop      = en && !qstat.empty;

	pwg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (qstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= !qstat.empty;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= pop_item;
			num_s2  <= item_s1.m.is_sine
			         ? (pwg_pkg::NUM_BITS'(item_s1.op) << pwg_pkg::PHASE_BITS)
			         : pwg_pkg::NUM_BITS'(item_s1.op) * pwg_pkg::NUM_BITS'(amp_q);
			div_s2  <= item_s1.divisor;
			meta_s2 <= item_s1.m;
		end
	end

	pwg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (num_s2),
		.divisor   (div_s2),
		.in_meta   (meta_s2),
		.res_valid (dv_valid),
		.res       (dv_res)
	);

	pwg_sine u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_res    (dv_res),
		.out_valid (sn_valid),
		.out_res   (sn_res),
		.out_soff  (sn_soff)
	);

	assign sine_prod = (pwg_pkg::SOFF_BITS + SB)'(sn_soff) * (pwg_pkg::SOFF_BITS + SB)'(amp_q);

	always_comb begin
		if (sn_res.m.direct) begin
			sample_d = sn_res.m.direct_val;
		end else if (sn_res.m.is_sine) begin
			sample_d = sine_prod[pwg_pkg::SOFF_BITS+SB-1:pwg_pkg::SOFF_BITS];
		end else begin
			sample_d = sn_res.q[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= sample_d;
			last_q   <= sn_res.m.last;
			oor_q    <= sn_res.m.oor;
		end
	end

	assign out_valid          = out_valid_q;
	assign sample_value       = sample_q;
	assign last_of_period     = last_q;
	assign index_out_of_range = oor_q;

`ifndef SYNTHESIS
	a_oor_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_out_of_range |-> sample_value == '0 && !last_of_period)
		else $error("out of range item with nonzero sample or last flag");

	a_queue_state : assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty together");

	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("queue filled without an accepted item");
`endif

endmodule

`default_nettype wire
